### rtl/dhfk_pkg.sv
// Package: shared types, constants and helper functions for the DH kinematics block.
package dhfk_pkg;

  localparam int unsigned CordicSteps = 28;
  localparam int unsigned StepW = (CordicSteps > 1) ? $clog2(CordicSteps) : 1;

  localparam logic signed [33:0] PiQ28     = 34'sd843314857;
  localparam logic signed [33:0] TwoPiQ28  = 34'sd1686629713;
  localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [35:0] GainQ30   = 36'sd652032874;
  localparam logic signed [31:0] OneQ30    = 32'sd1073741824;

  typedef struct packed {
    logic signed [31:0] link_length;
    logic signed [31:0] link_twist;
    logic signed [31:0] link_offset;
    logic signed [33:0] theta;
    logic               last_joint;
  } joint_t;

  typedef struct packed {
    logic signed [31:0] rot_00;
    logic signed [31:0] rot_01;
    logic signed [31:0] rot_02;
    logic signed [31:0] rot_10;
    logic signed [31:0] rot_11;
    logic signed [31:0] rot_12;
    logic signed [31:0] rot_20;
    logic signed [31:0] rot_21;
    logic signed [31:0] rot_22;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } pose_t;

  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic signed [35:0] r;
    case (i)
      5'd0: r = 36'sd843314857;
      5'd1: r = 36'sd497837829;
      5'd2: r = 36'sd263043837;
      5'd3: r = 36'sd133525159;
      5'd4: r = 36'sd67021687;
      5'd5: r = 36'sd33543516;
      5'd6: r = 36'sd16775851;
      5'd7: r = 36'sd8388437;
      5'd8: r = 36'sd4194283;
      5'd9: r = 36'sd2097149;
      5'd31: r = 36'sd0;
      default: r = 36'sd1 <<< (5'd30 - i);
    endcase
    return r;
  endfunction

  // round half up after the Q30 shift
  function automatic logic signed [63:0] rnd_q30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd536870912;
    return t >>> 30;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7fffffff;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### rtl/dhfk_stream_if.sv
// Interfaces: valid/ready channels for joint words and pose words.
interface dhfk_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] link_length;
  logic signed [31:0] link_twist;
  logic signed [31:0] link_offset;
  logic signed [31:0] angle_offset;
  logic signed [31:0] joint_angle;
  logic               last_joint;
  modport source (output valid, link_length, link_twist, link_offset, angle_offset,
                  joint_angle, last_joint, input ready);
  modport sink (input valid, link_length, link_twist, link_offset, angle_offset,
                joint_angle, last_joint, output ready);
endinterface

interface dhfk_out_if;
  logic                 valid;
  logic                 ready;
  dhfk_pkg::pose_t      pose;
  modport source (output valid, pose, input ready);
  modport sink (input valid, pose, output ready);
endinterface

### rtl/dhfk_front.sv
// Front end: accept joint words, form theta, hold two-entry queue to the back end.
module dhfk_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  dhfk_in_if.sink             in_i,
  output logic                q_valid_o,
  output dhfk_pkg::joint_t    q_data_o,
  input  logic                q_pop_i
);
  dhfk_pkg::joint_t mem_q [2];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;
  dhfk_pkg::joint_t w;
  logic push;

  always_comb begin
    w.link_length = in_i.link_length;
    w.link_twist  = in_i.link_twist;
    w.link_offset = in_i.link_offset;
    w.theta       = 34'(in_i.angle_offset) + 34'(in_i.joint_angle);
    w.last_joint  = in_i.last_joint;
  end

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end
endmodule

### rtl/dhfk_cordic.sv
// Shared rotation-mode CORDIC: cos and sin of two angles in sequence.
module dhfk_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [33:0] ang_i,
  output logic               done_o,
  output logic signed [35:0] cos_o,
  output logic signed [35:0] sin_o
);
  typedef enum logic [1:0] {IDLE, FOLD, ITER, FIN} state_e;
  state_e state_q;
  logic signed [35:0] x_q, y_q, z_q, a_q;
  logic neg_q;
  logic [dhfk_pkg::StepW-1:0] i_q;
  logic signed [35:0] red;

  always_comb begin
    red = a_q;
    if (a_q > 36'(dhfk_pkg::PiQ28)) red = a_q - 36'(dhfk_pkg::TwoPiQ28);
    else if (a_q < -36'(dhfk_pkg::PiQ28)) red = a_q + 36'(dhfk_pkg::TwoPiQ28);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE; done_o <= 1'b0;
      x_q <= '0; y_q <= '0; z_q <= '0; a_q <= '0; neg_q <= 1'b0; i_q <= '0;
      cos_o <= '0; sin_o <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        IDLE: if (start_i) begin
          a_q <= 36'(ang_i); state_q <= FOLD;
        end
        FOLD: begin
          // reduce one 2*pi step per cycle until in range
          if (red != a_q) a_q <= red;
          else begin
            x_q <= dhfk_pkg::GainQ30; y_q <= '0; i_q <= '0; state_q <= ITER;
            if ((a_q <<< 2) > dhfk_pkg::HalfPiQ30) begin
              z_q <= (a_q <<< 2) - dhfk_pkg::PiQ30; neg_q <= 1'b1;
            end else if ((a_q <<< 2) < -dhfk_pkg::HalfPiQ30) begin
              z_q <= (a_q <<< 2) + dhfk_pkg::PiQ30; neg_q <= 1'b1;
            end else begin
              z_q <= a_q <<< 2; neg_q <= 1'b0;
            end
          end
        end
        ITER: begin
          if (z_q >= 0) begin
            x_q <= x_q - (y_q >>> i_q); y_q <= y_q + (x_q >>> i_q);
            z_q <= z_q - dhfk_pkg::atan_q30(5'(i_q));
          end else begin
            x_q <= x_q + (y_q >>> i_q); y_q <= y_q - (x_q >>> i_q);
            z_q <= z_q + dhfk_pkg::atan_q30(5'(i_q));
          end
          if (i_q == dhfk_pkg::StepW'(dhfk_pkg::CordicSteps - 1)) state_q <= FIN;
          else i_q <= i_q + 1'b1;
        end
        FIN: begin
          cos_o <= neg_q ? -x_q : x_q; sin_o <= neg_q ? -y_q : y_q;
          done_o <= 1'b1; state_q <= IDLE;
        end
        default: state_q <= IDLE;
      endcase
    end
  end
endmodule

### rtl/dhfk_back.sv
// Back end: link transform terms, then the pose product through one shared multiplier.
module dhfk_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  dhfk_pkg::joint_t q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  output dhfk_pkg::pose_t  out_pose_o,
  input  logic             out_ready_i
);
  typedef enum logic [2:0] {IDLE, CTH, CAL, LNK, MAT, WB, EMIT} state_e;
  state_e state_q;
  dhfk_pkg::joint_t j_q;
  logic signed [35:0] ct_q, st_q, ca_q, sa_q;
  logic signed [31:0] pose_q [12];
  logic signed [31:0] nxt_q [12];
  logic signed [35:0] lr_q [9];
  logic signed [31:0] lp_q [3];
  logic [3:0] k_q;  // product step
  logic [1:0] t_q;  // term
  logic signed [35:0] acc_q;
  logic c_start;
  logic signed [33:0] c_ang;
  logic c_done;
  logic signed [35:0] c_cos, c_sin;
  logic signed [63:0] ma, mb, mp;
  logic [1:0] r_idx, c_idx;
  logic [3:0] ent;

  dhfk_cordic u_cordic (.clk_i, .rst_ni, .start_i(c_start), .ang_i(c_ang),
    .done_o(c_done), .cos_o(c_cos), .sin_o(c_sin));

  assign c_start = (state_q == IDLE && q_valid_i) || (state_q == CTH && c_done);
  assign c_ang   = (state_q == IDLE) ? q_data_i.theta : 34'(j_q.link_twist);
  assign q_pop_o = (state_q == IDLE) && q_valid_i;

  // k_q: 0..11 entries, row r = k/4, col = k%4 (col 3 = translation)
  assign r_idx = k_q[3:2];
  assign c_idx = k_q[1:0];
  assign ent   = 4'(r_idx) * 4'd3 + 4'(t_q);

  always_comb begin
    ma = 64'(pose_q[ent]);
    if (c_idx == 2'd3) mb = 64'(lp_q[t_q]);
    else mb = 64'(lr_q[4'(t_q) * 4'd3 + 4'(c_idx)]);
    mp = ma * mb;
  end

  always_comb begin
    out_pose_o.rot_00 = pose_q[0]; out_pose_o.rot_01 = pose_q[1];
    out_pose_o.rot_02 = pose_q[2]; out_pose_o.rot_10 = pose_q[3];
    out_pose_o.rot_11 = pose_q[4]; out_pose_o.rot_12 = pose_q[5];
    out_pose_o.rot_20 = pose_q[6]; out_pose_o.rot_21 = pose_q[7];
    out_pose_o.rot_22 = pose_q[8]; out_pose_o.pos_x = pose_q[9];
    out_pose_o.pos_y = pose_q[10]; out_pose_o.pos_z = pose_q[11];
  end
  assign out_valid_o = (state_q == EMIT);

  always_ff @(posedge clk_i) begin
    if (q_pop_o) j_q <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE; k_q <= '0; t_q <= '0; acc_q <= '0;
      ct_q <= '0; st_q <= '0; ca_q <= '0; sa_q <= '0;
      for (int i = 0; i < 12; i++) begin
        pose_q[i] <= '0; nxt_q[i] <= '0;
      end
      pose_q[0] <= dhfk_pkg::OneQ30; pose_q[4] <= dhfk_pkg::OneQ30;
      pose_q[8] <= dhfk_pkg::OneQ30;
      for (int i = 0; i < 9; i++) lr_q[i] <= '0;
      for (int i = 0; i < 3; i++) lp_q[i] <= '0;
    end else begin
      unique case (state_q)
        IDLE: if (q_valid_i) state_q <= CTH;
        CTH: if (c_done) begin
          ct_q <= c_cos; st_q <= c_sin; state_q <= CAL;
        end
        CAL: if (c_done) begin
          ca_q <= c_cos; sa_q <= c_sin; k_q <= '0; state_q <= LNK;
        end
        LNK: begin
          // one link term per cycle
          unique case (k_q)
            4'd0: lr_q[1] <= -36'(dhfk_pkg::rnd_q30(64'(st_q) * 64'(ca_q)));
            4'd1: lr_q[2] <= 36'(dhfk_pkg::rnd_q30(64'(st_q) * 64'(sa_q)));
            4'd2: lr_q[4] <= 36'(dhfk_pkg::rnd_q30(64'(ct_q) * 64'(ca_q)));
            4'd3: lr_q[5] <= -36'(dhfk_pkg::rnd_q30(64'(ct_q) * 64'(sa_q)));
            4'd4: lp_q[0] <= dhfk_pkg::sat32(36'(dhfk_pkg::rnd_q30(
                    64'(j_q.link_length) * 64'(ct_q))));
            default: lp_q[1] <= dhfk_pkg::sat32(36'(dhfk_pkg::rnd_q30(
                    64'(j_q.link_length) * 64'(st_q))));
          endcase
          lr_q[0] <= ct_q; lr_q[3] <= st_q; lr_q[6] <= '0;
          lr_q[7] <= sa_q; lr_q[8] <= ca_q; lp_q[2] <= j_q.link_offset;
          if (k_q == 4'd5) begin
            k_q <= '0; t_q <= '0; acc_q <= '0; state_q <= MAT;
          end else k_q <= k_q + 4'd1;
        end
        MAT: begin
          if (t_q == 2'd2) begin
            nxt_q[4'(r_idx) * 4'd3 + ((c_idx == 2'd3) ? 4'd9 - 4'(r_idx) * 4'd2 :
                  4'(c_idx))] <= dhfk_pkg::sat32(acc_q + 36'(dhfk_pkg::rnd_q30(mp))
                  + ((c_idx == 2'd3) ? 36'(pose_q[4'd9 + 4'(r_idx)]) : 36'sd0));
            acc_q <= '0; t_q <= '0;
            if (k_q == 4'd11) state_q <= WB;
            else if (c_idx == 2'd3) k_q <= k_q + 4'd1;
            else k_q <= k_q + 4'd1;
          end else begin
            acc_q <= acc_q + 36'(dhfk_pkg::rnd_q30(mp));
            t_q <= t_q + 2'd1;
          end
          if (t_q == 2'd2 && c_idx == 2'd3 && k_q != 4'd11) k_q <= k_q + 4'd1;
        end
        WB: begin
          for (int i = 0; i < 12; i++) pose_q[i] <= nxt_q[i];
          state_q <= j_q.last_joint ? EMIT : IDLE;
        end
        EMIT: if (out_ready_i) begin
          for (int i = 0; i < 12; i++) pose_q[i] <= '0;
          pose_q[0] <= dhfk_pkg::OneQ30; pose_q[4] <= dhfk_pkg::OneQ30;
          pose_q[8] <= dhfk_pkg::OneQ30;
          state_q <= IDLE;
        end
        default: state_q <= IDLE;
      endcase
    end
  end
endmodule

### rtl/dh_forward_kinematics.sv
// Top level: DH forward kinematics, one joint word in, one pose word per chain.
// Each joint runs the shared CORDIC twice, then the link terms, then the pose product
// through a single multiplier; the back end takes one joint at a time and a two-word
// queue lets input run ahead.
// Reset: asynchronous active low; pose returns to identity, queue empties.
module dh_forward_kinematics (
  input  logic  clk_i,
  input  logic  rst_ni,
  dhfk_in_if.sink    in_i,
  dhfk_out_if.source out_o
);
  logic             q_valid, q_pop;
  dhfk_pkg::joint_t q_data;

  dhfk_front u_front (.clk_i, .rst_ni, .in_i, .q_valid_o(q_valid),
    .q_data_o(q_data), .q_pop_i(q_pop));

  dhfk_back u_back (.clk_i, .rst_ni, .q_valid_i(q_valid), .q_data_i(q_data),
    .q_pop_o(q_pop), .out_valid_o(out_o.valid), .out_pose_o(out_o.pose),
    .out_ready_i(out_o.ready));

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && !q_pop)
    else $error("result dropped");
endmodule

### dv/dh_forward_kinematics_test.sv
// Testbench for the DH forward kinematics block: chained joints against a bit-exact pose model.
module dh_forward_kinematics_test;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  dhfk_in_if  joint_ch ();
  dhfk_out_if pose_ch ();

  dh_forward_kinematics i_dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(joint_ch), .out_o(pose_ch));

  typedef struct {
    logic signed [31:0] a, alpha, d, th_off, q;
    logic               last;
  } joint_word_t;

  longint           pose_acc[12];
  dhfk_pkg::pose_t  pose_queue[$];
  int     n_errors = 0;
  int     idle_cycles = 0;
  bit     hold_off = 1'b0;
  bit     rand_stall = 1'b1;

  localparam longint AtanTab[32] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851, 8388437,
    4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul(longint x, longint y);
    return (x * y + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic cordic_cos_sin(input longint ang, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    flip = 1'b0;
    while (ang > 64'sd843314857) ang -= 64'sd1686629713;
    while (ang < -64'sd843314857) ang += 64'sd1686629713;
    z = ang * 4;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1'b1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1'b1;
    end
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < dhfk_pkg::CordicSteps && i < 32; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTab[i];
      end else begin
        x += dx; y -= dy; z += AtanTab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic void pose_to_identity();
    foreach (pose_acc[k]) pose_acc[k] = 0;
    pose_acc[0] = 64'sd1073741824;
    pose_acc[4] = 64'sd1073741824;
    pose_acc[8] = 64'sd1073741824;
  endfunction

  task automatic chain_joint(input joint_word_t w);
    longint ct, st, ca, sa, acc;
    longint lr[9], lp[3], nxt[12];
    dhfk_pkg::pose_t p;
    cordic_cos_sin(longint'(w.th_off) + longint'(w.q), ct, st);
    cordic_cos_sin(longint'(w.alpha), ca, sa);
    lr[0] = ct; lr[1] = -qmul(st, ca); lr[2] = qmul(st, sa);
    lr[3] = st; lr[4] = qmul(ct, ca);  lr[5] = -qmul(ct, sa);
    lr[6] = 0;  lr[7] = sa;            lr[8] = ca;
    lp[0] = clip32(qmul(w.a, ct));
    lp[1] = clip32(qmul(w.a, st));
    lp[2] = w.d;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        acc = qmul(pose_acc[r*3], lr[k]) + qmul(pose_acc[r*3+1], lr[3+k])
            + qmul(pose_acc[r*3+2], lr[6+k]);
        nxt[r*3+k] = clip32(acc);
      end
      acc = qmul(pose_acc[r*3], lp[0]) + qmul(pose_acc[r*3+1], lp[1])
          + qmul(pose_acc[r*3+2], lp[2]) + pose_acc[9+r];
      nxt[9+r] = clip32(acc);
    end
    pose_acc = nxt;
    if (w.last) begin
      p.rot_00 = 32'(pose_acc[0]); p.rot_01 = 32'(pose_acc[1]); p.rot_02 = 32'(pose_acc[2]);
      p.rot_10 = 32'(pose_acc[3]); p.rot_11 = 32'(pose_acc[4]); p.rot_12 = 32'(pose_acc[5]);
      p.rot_20 = 32'(pose_acc[6]); p.rot_21 = 32'(pose_acc[7]); p.rot_22 = 32'(pose_acc[8]);
      p.pos_x = 32'(pose_acc[9]); p.pos_y = 32'(pose_acc[10]); p.pos_z = 32'(pose_acc[11]);
      pose_queue.push_back(p);
      pose_to_identity();
    end
  endtask

  task automatic send_joint(input joint_word_t w);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      joint_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    joint_ch.valid <= 1'b1;
    joint_ch.link_length <= w.a;
    joint_ch.link_twist <= w.alpha;
    joint_ch.link_offset <= w.d;
    joint_ch.angle_offset <= w.th_off;
    joint_ch.joint_angle <= w.q;
    joint_ch.last_joint <= w.last;
    do @(posedge clk_i); while (!joint_ch.ready);
    chain_joint(w);
    @(negedge clk_i);
  endtask

  task automatic stop_input();
    joint_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return $signed($urandom_range(0, 32'h3fffffff)) - 32'sh20000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic joint_word_t rand_joint(bit last);
    joint_word_t w;
    w.a = rand_word(); w.alpha = rand_word(); w.d = rand_word();
    w.th_off = rand_word(); w.q = rand_word(); w.last = last;
    if ($urandom_range(0, 2) != 0) begin
      w.a = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
      w.d = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
    end
    return w;
  endfunction

  task automatic send_chain(int n_joints);
    for (int j = 1; j <= n_joints; j++) send_joint(rand_joint(j == n_joints));
  endtask

  task automatic drain();
    while (pose_queue.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    joint_word_t w;
    logic signed [31:0] angles[8] = '{0, 32'sh7fffffff, 32'sh80000000, 843314857,
                                      -843314857, 421657428, -421657428, 1686629713};
    foreach (angles[k]) begin
      w = '{a: 32'sh00010000, alpha: angles[k], d: 32'sh00020000,
            th_off: angles[7-k], q: angles[k], last: 1'b1};
      send_joint(w);
    end
    w = '{a: 32'sh7fffffff, alpha: 0, d: 32'sh7fffffff, th_off: 0, q: 0, last: 1'b0};
    send_joint(w);
    send_joint(w);
    w.a = 32'sh80000000; w.d = 32'sh80000000; w.last = 1'b1;
    send_joint(w);
    w = '{a: 32'sh80000000, alpha: 32'sh80000000, d: 32'sh80000000,
          th_off: 32'sh80000000, q: 32'sh80000000, last: 1'b1};
    send_joint(w);
    w = '{a: -1, alpha: -1, d: -1, th_off: -1, q: -1, last: 1'b1};
    send_joint(w);
    for (int k = 0; k < 6; k++) send_joint(rand_joint(k == 5));
    stop_input();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(negedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_chain(1);
        send_chain(1);
        send_chain(2);
        send_chain(1);
        stop_input();
      end
    join
    drain();
  endtask

  task automatic test_random();
    int n_sent;
    n_sent = 0;
    while (n_sent < 2000) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
      rand_stall = ($urandom_range(0, 4) != 0);
      send_chain(len);
      n_sent += len;
    end
    stop_input();
  endtask

  initial begin
    joint_ch.valid = 1'b0;
    joint_ch.link_length = '0; joint_ch.link_twist = '0; joint_ch.link_offset = '0;
    joint_ch.angle_offset = '0; joint_ch.joint_angle = '0; joint_ch.last_joint = 1'b0;
    pose_to_identity();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    drain();
    repeat (300) @(negedge clk_i);
    if (n_errors == 0 && pose_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    int stall;
    pose_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        pose_ch.ready <= 1'b0;
      end else begin
        stall = rand_stall ? $urandom_range(0, 6) : 0;
        if (stall != 0) begin
          pose_ch.ready <= 1'b0;
          repeat (stall - 1) @(negedge clk_i);
          @(negedge clk_i);
        end
        if (!hold_off) begin
          pose_ch.ready <= 1'b1;
          do @(posedge clk_i); while (!(pose_ch.valid && pose_ch.ready) && !hold_off);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    dhfk_pkg::pose_t exp_p, got;
    if (rst_ni && pose_ch.valid && pose_ch.ready) begin
      got = pose_ch.pose;
      if (pose_queue.size() == 0) begin
        $error("unexpected pose word");
        n_errors++;
      end else begin
        exp_p = pose_queue.pop_front();
        if (got.rot_00 !== exp_p.rot_00) begin
          $error("rot_00 exp %0d got %0d", exp_p.rot_00, got.rot_00); n_errors++;
        end
        if (got.rot_01 !== exp_p.rot_01) begin
          $error("rot_01 exp %0d got %0d", exp_p.rot_01, got.rot_01); n_errors++;
        end
        if (got.rot_02 !== exp_p.rot_02) begin
          $error("rot_02 exp %0d got %0d", exp_p.rot_02, got.rot_02); n_errors++;
        end
        if (got.rot_10 !== exp_p.rot_10) begin
          $error("rot_10 exp %0d got %0d", exp_p.rot_10, got.rot_10); n_errors++;
        end
        if (got.rot_11 !== exp_p.rot_11) begin
          $error("rot_11 exp %0d got %0d", exp_p.rot_11, got.rot_11); n_errors++;
        end
        if (got.rot_12 !== exp_p.rot_12) begin
          $error("rot_12 exp %0d got %0d", exp_p.rot_12, got.rot_12); n_errors++;
        end
        if (got.rot_20 !== exp_p.rot_20) begin
          $error("rot_20 exp %0d got %0d", exp_p.rot_20, got.rot_20); n_errors++;
        end
        if (got.rot_21 !== exp_p.rot_21) begin
          $error("rot_21 exp %0d got %0d", exp_p.rot_21, got.rot_21); n_errors++;
        end
        if (got.rot_22 !== exp_p.rot_22) begin
          $error("rot_22 exp %0d got %0d", exp_p.rot_22, got.rot_22); n_errors++;
        end
        if (got.pos_x !== exp_p.pos_x) begin
          $error("pos_x exp %0d got %0d", exp_p.pos_x, got.pos_x); n_errors++;
        end
        if (got.pos_y !== exp_p.pos_y) begin
          $error("pos_y exp %0d got %0d", exp_p.pos_y, got.pos_y); n_errors++;
        end
        if (got.pos_z !== exp_p.pos_z) begin
          $error("pos_z exp %0d got %0d", exp_p.pos_z, got.pos_z); n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((joint_ch.valid && joint_ch.ready) || (pose_ch.valid && pose_ch.ready) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
